[sv/motion_magnitude_adaptive_filter_assert.svh]
// Assertion macros used by the checker of the motion magnitude filter.
// Depends on nothing; the including file supplies the clock and reset names.
`ifndef MOTION_MAGNITUDE_ADAPTIVE_FILTER_ASSERT_SVH
`define MOTION_MAGNITUDE_ADAPTIVE_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMAF_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("motion magnitude filter: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MMAF_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("motion magnitude filter: next-cycle check failed");

`endif

[sv/mmaf_pkg.sv]
// Types, constants and the gain adaptation function of the motion magnitude filter.
// Used by the top level and by the square root unit; depends on nothing.
package mmaf_pkg;

   // Field and datapath widths.
   localparam int AXES      = 3;
   localparam int AXIS_W    = 13;
   localparam int MAG_W     = 14;
   localparam int GAIN_W    = 8;
   localparam int COUNT_W   = 8;
   localparam int SUM_W     = 28;
   localparam int ROOT_W    = 14;
   localparam int REM_W     = ROOT_W + 1;
   localparam int STEP_W    = $clog2(ROOT_W);
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 14;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_GAIN_BASE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_GAIN_STEP  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_BIG_CHANGE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_CNT_LIMIT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAG_GAIN_BASE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAG_GAIN_STEP   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MAG_CLIP_MAX    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MAG_FLOOR_MIN   = 3'd7;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AXIS_ADAPT,
      ST_AXIS_BLEND,
      ST_AXIS_SQUARE,
      ST_SQRT_START,
      ST_SQRT_WAIT,
      ST_MAG_ADAPT,
      ST_MAG_BLEND
   } state_type;

   // Request from the sequencer to the square root unit.
   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] radicand;
   } sqrt_req_type;

   // Updated count and gain of one adaptive filter.
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [GAIN_W-1:0]  gain;
   } adapt_type;

   // Gain adaptation: count same-direction steps and raise the gain past the limit,
   // or fall back to the base gain when the direction flips.
   function automatic adapt_type adapt_fn(
      input logic               same_dir,
      input logic               big_change,
      input logic [COUNT_W-1:0] count,
      input logic [GAIN_W-1:0]  gain,
      input logic [COUNT_W-1:0] bonus,
      input logic [COUNT_W-1:0] limit,
      input logic [GAIN_W-1:0]  base,
      input logic [GAIN_W-1:0]  step
   );
      adapt_type          res;
      logic [COUNT_W-1:0] c;
      res.count = count;
      res.gain  = gain;
      if (same_dir) begin
         c = count + 8'd1;
         if (big_change) begin
            c = c + bonus;
         end
         if (c > limit) begin
            res.gain = gain + step;
            c        = '0;
         end
         res.count = c;
      end else begin
         res.count = '0;
         res.gain  = base;
      end
      return res;
   endfunction

endpackage

[sv/mmaf_isqrt.sv]
// Restoring integer square root, one result bit per cycle.
// Depends on mmaf_pkg for widths and the request struct.
module mmaf_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  mmaf_pkg::sqrt_req_type       sq_req,
   output logic                         sq_done,
   output logic [mmaf_pkg::ROOT_W-1:0]  sq_root
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [mmaf_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [mmaf_pkg::SUM_W-1:0]    rad_ff, rad_in;
   logic [mmaf_pkg::REM_W-1:0]    rem_ff, rem_in;
   logic [mmaf_pkg::ROOT_W-1:0]   root_ff, root_in;

   logic [mmaf_pkg::REM_W+1:0]    rem_sh;
   logic [mmaf_pkg::REM_W+1:0]    trial;
   logic [mmaf_pkg::REM_W+1:0]    rem_sub;
   logic                          fits;

   // Bring down the next two radicand bits and try the next root bit.
   assign rem_sh  = {rem_ff, rad_ff[mmaf_pkg::SUM_W-1 -: 2]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign rem_sub = rem_sh - trial;
   assign fits    = (rem_sh >= trial);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (sq_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rad_in  = sq_req.radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[mmaf_pkg::SUM_W-3:0], 2'b00};
         rem_in  = fits ? rem_sub[mmaf_pkg::REM_W-1:0] : rem_sh[mmaf_pkg::REM_W-1:0];
         root_in = {root_ff[mmaf_pkg::ROOT_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == mmaf_pkg::STEP_W'(mmaf_pkg::ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign sq_done = done_ff;
   assign sq_root = root_ff;

endmodule

[sv/motion_magnitude_adaptive_filter.sv]
// Motion magnitude filter: one word in, one word out.
// A small sequencer walks the three axes through one shared 16 by 16 multiplier, with a
// gain update, a blend and a square-and-accumulate step for each axis; then the square
// root unit produces one bit of the magnitude per cycle, and the magnitude is adapted
// and blended. The result lands in an output register, and the block accepts the next
// word in the same cycle as that result is offered, even if the result is still waiting;
// the final blend waits only if the previous result is unread.
// The user writes configuration registers only while the block is idle; the block itself
// does not enforce this. Depends on mmaf_pkg and mmaf_isqrt.
module motion_magnitude_adaptive_filter #(
   parameter int AXIS_COUNT_BONUS = 2,
   parameter int MAG_COUNT_BONUS  = 2,
   parameter int MAG_BIG_CHANGE   = 50,
   parameter int MAG_COUNT_LIMIT  = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [mmaf_pkg::AXIS_W-1:0]   req_accel_x,
   input  logic signed [mmaf_pkg::AXIS_W-1:0]   req_accel_y,
   input  logic signed [mmaf_pkg::AXIS_W-1:0]   req_accel_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mmaf_pkg::MAG_W-1:0]           rsp_motion_magnitude,
   input  logic                                 csr_wr_en,
   input  logic [mmaf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mmaf_pkg::CSR_W-1:0]           csr_wdata
);

   localparam int IDX_W = $clog2(mmaf_pkg::AXES);

   // Configuration registers.
   logic [7:0]  axis_gain_base_ff, axis_gain_step_ff;
   logic [12:0] axis_big_change_ff;
   logic [6:0]  axis_count_limit_ff;
   logic [7:0]  mag_gain_base_ff, mag_gain_step_ff;
   logic [13:0] mag_clip_max_ff, mag_floor_min_ff;

   // Sequencer and per-word working registers.
   mmaf_pkg::state_type                  state_ff, state_in;
   logic [IDX_W-1:0]                     idx_ff, idx_in;
   logic signed [mmaf_pkg::AXIS_W-1:0]   accel_ff [mmaf_pkg::AXES];
   logic signed [mmaf_pkg::AXIS_W-1:0]   accel_in [mmaf_pkg::AXES];
   logic [mmaf_pkg::AXIS_W:0]            diff_ff, diff_in;
   logic [mmaf_pkg::AXIS_W:0]            ch_ff, ch_in;
   logic [mmaf_pkg::SUM_W-1:0]           sum_ff, sum_in;
   logic [mmaf_pkg::MAG_W:0]             mdiff_ff, mdiff_in;

   // Axis filter state.
   logic [mmaf_pkg::AXIS_W-1:0]          prev_ff [mmaf_pkg::AXES];
   logic [mmaf_pkg::AXIS_W-1:0]          prev_in [mmaf_pkg::AXES];
   logic                                 rising_ff [mmaf_pkg::AXES];
   logic                                 rising_in [mmaf_pkg::AXES];
   logic [mmaf_pkg::COUNT_W-1:0]         count_ff [mmaf_pkg::AXES];
   logic [mmaf_pkg::COUNT_W-1:0]         count_in [mmaf_pkg::AXES];
   logic [mmaf_pkg::GAIN_W-1:0]          gain_ff [mmaf_pkg::AXES];
   logic [mmaf_pkg::GAIN_W-1:0]          gain_in [mmaf_pkg::AXES];

   // Magnitude filter state.
   logic [mmaf_pkg::MAG_W-1:0]           mprev_ff, mprev_in;
   logic                                 mrising_ff, mrising_in;
   logic [mmaf_pkg::COUNT_W-1:0]         mcount_ff, mcount_in;
   logic [mmaf_pkg::GAIN_W-1:0]          mgain_ff, mgain_in;

   // Output register.
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [mmaf_pkg::MAG_W-1:0]           rsp_mag_ff, rsp_mag_in;

   // Shared multiplier and divide-by-256 rounding toward zero.
   logic signed [15:0]                   mul_a, mul_b;
   logic signed [31:0]                   mul_p, mul_adj, mul_q;

   // Axis step terms.
   logic [mmaf_pkg::AXIS_W-1:0]          ax_x, ax_p;
   logic [mmaf_pkg::AXIS_W:0]            ax_d, ax_abs, ax_nv;
   logic                                 ax_rise, ax_big;
   mmaf_pkg::adapt_type                  ax_upd;

   // Magnitude step terms.
   logic [mmaf_pkg::MAG_W-1:0]           mg_raw, mg_abs, mg_val, mg_out;
   logic [mmaf_pkg::MAG_W:0]             mg_d, mg_neg, mg_sum;
   logic                                 mg_rise, mg_big;
   mmaf_pkg::adapt_type                  mg_upd;

   logic                                 out_free;
   mmaf_pkg::sqrt_req_type               sq_req;
   logic                                 sq_done;
   logic [mmaf_pkg::ROOT_W-1:0]          sq_root;

   mmaf_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .sq_req  (sq_req),
      .sq_done (sq_done),
      .sq_root (sq_root)
   );

   // Configuration writes; the index covers exactly the eight registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_gain_base_ff   <= 8'd32;
         axis_gain_step_ff   <= 8'd16;
         axis_big_change_ff  <= 13'd50;
         axis_count_limit_ff <= 7'd10;
         mag_gain_base_ff    <= 8'd32;
         mag_gain_step_ff    <= 8'd16;
         mag_clip_max_ff     <= 14'd2000;
         mag_floor_min_ff    <= 14'd0;
      end else if (csr_wr_en) begin
         case (csr_index)
            mmaf_pkg::CSR_AXIS_GAIN_BASE:  axis_gain_base_ff   <= csr_wdata[7:0];
            mmaf_pkg::CSR_AXIS_GAIN_STEP:  axis_gain_step_ff   <= csr_wdata[7:0];
            mmaf_pkg::CSR_AXIS_BIG_CHANGE: axis_big_change_ff  <= csr_wdata[12:0];
            mmaf_pkg::CSR_AXIS_CNT_LIMIT:  axis_count_limit_ff <= csr_wdata[6:0];
            mmaf_pkg::CSR_MAG_GAIN_BASE:   mag_gain_base_ff    <= csr_wdata[7:0];
            mmaf_pkg::CSR_MAG_GAIN_STEP:   mag_gain_step_ff    <= csr_wdata[7:0];
            mmaf_pkg::CSR_MAG_CLIP_MAX:    mag_clip_max_ff     <= csr_wdata;
            mmaf_pkg::CSR_MAG_FLOOR_MIN:   mag_floor_min_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Multiplier operand selection by sequencer state.
   always_comb begin
      case (state_ff)
         mmaf_pkg::ST_AXIS_BLEND: begin
            mul_a = {{2{diff_ff[mmaf_pkg::AXIS_W]}}, diff_ff};
            mul_b = {8'd0, gain_ff[idx_ff]};
         end
         mmaf_pkg::ST_AXIS_SQUARE: begin
            mul_a = {{2{ch_ff[mmaf_pkg::AXIS_W]}}, ch_ff};
            mul_b = {{2{ch_ff[mmaf_pkg::AXIS_W]}}, ch_ff};
         end
         mmaf_pkg::ST_MAG_BLEND: begin
            mul_a = {mdiff_ff[mmaf_pkg::MAG_W], mdiff_ff};
            mul_b = {8'd0, mgain_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p   = mul_a * mul_b;
   assign mul_adj = mul_p + (mul_p[31] ? 32'sd255 : 32'sd0);
   assign mul_q   = mul_adj >>> 8;

   // Axis difference, direction and gain update for the axis in turn.
   assign ax_x    = accel_ff[idx_ff];
   assign ax_p    = prev_ff[idx_ff];
   assign ax_d    = {ax_x[mmaf_pkg::AXIS_W-1], ax_x} - {ax_p[mmaf_pkg::AXIS_W-1], ax_p};
   assign ax_rise = !ax_d[mmaf_pkg::AXIS_W] && (ax_d != '0);
   assign ax_abs  = ax_d[mmaf_pkg::AXIS_W] ? (~ax_d + 1'b1) : ax_d;
   assign ax_big  = (ax_abs > {1'b0, axis_big_change_ff});
   assign ax_upd  = mmaf_pkg::adapt_fn(ax_rise == rising_ff[idx_ff], ax_big,
                                       count_ff[idx_ff], gain_ff[idx_ff],
                                       8'(AXIS_COUNT_BONUS), {1'b0, axis_count_limit_ff},
                                       axis_gain_base_ff, axis_gain_step_ff);
   assign ax_nv   = {ax_p[mmaf_pkg::AXIS_W-1], ax_p} + mul_q[mmaf_pkg::AXIS_W:0];

   // Clipped raw magnitude, its change and gain update.
   assign mg_raw  = (sq_root > mag_clip_max_ff) ? mag_clip_max_ff : sq_root;
   assign mg_d    = {1'b0, mg_raw} - {1'b0, mprev_ff};
   assign mg_rise = !mg_d[mmaf_pkg::MAG_W] && (mg_d != '0);
   assign mg_neg  = ~mg_d + 1'b1;
   assign mg_abs  = mg_d[mmaf_pkg::MAG_W] ? mg_neg[mmaf_pkg::MAG_W-1:0]
                                          : mg_d[mmaf_pkg::MAG_W-1:0];
   assign mg_big  = (mg_abs > 14'(MAG_BIG_CHANGE));
   assign mg_upd  = mmaf_pkg::adapt_fn(mg_rise == mrising_ff, mg_big, mcount_ff, mgain_ff,
                                       8'(MAG_COUNT_BONUS), 8'(MAG_COUNT_LIMIT),
                                       mag_gain_base_ff, mag_gain_step_ff);

   // Magnitude blend and floor test.
   assign mg_sum  = {1'b0, mprev_ff} + mul_q[mmaf_pkg::MAG_W:0];
   assign mg_val  = mg_sum[mmaf_pkg::MAG_W-1:0];
   assign mg_out  = (mg_val < mag_floor_min_ff) ? '0 : mg_val;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer: next state and datapath updates.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      accel_in     = accel_ff;
      diff_in      = diff_ff;
      ch_in        = ch_ff;
      sum_in       = sum_ff;
      mdiff_in     = mdiff_ff;
      prev_in      = prev_ff;
      rising_in    = rising_ff;
      count_in     = count_ff;
      gain_in      = gain_ff;
      mprev_in     = mprev_ff;
      mrising_in   = mrising_ff;
      mcount_in    = mcount_ff;
      mgain_in     = mgain_ff;
      rsp_mag_in   = rsp_mag_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      sq_req.start    = 1'b0;
      sq_req.radicand = sum_ff;
      case (state_ff)
         mmaf_pkg::ST_IDLE: begin
            if (req_valid) begin
               accel_in[0] = req_accel_x;
               accel_in[1] = req_accel_y;
               accel_in[2] = req_accel_z;
               idx_in      = '0;
               sum_in      = '0;
               state_in    = mmaf_pkg::ST_AXIS_ADAPT;
            end
         end
         mmaf_pkg::ST_AXIS_ADAPT: begin
            diff_in           = ax_d;
            count_in[idx_ff]  = ax_upd.count;
            gain_in[idx_ff]   = ax_upd.gain;
            rising_in[idx_ff] = ax_rise;
            state_in          = mmaf_pkg::ST_AXIS_BLEND;
         end
         mmaf_pkg::ST_AXIS_BLEND: begin
            ch_in           = mul_q[mmaf_pkg::AXIS_W:0];
            prev_in[idx_ff] = ax_nv[mmaf_pkg::AXIS_W-1:0];
            state_in        = mmaf_pkg::ST_AXIS_SQUARE;
         end
         mmaf_pkg::ST_AXIS_SQUARE: begin
            sum_in = sum_ff + mul_p[mmaf_pkg::SUM_W-1:0];
            if (idx_ff == IDX_W'(mmaf_pkg::AXES - 1)) begin
               state_in = mmaf_pkg::ST_SQRT_START;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = mmaf_pkg::ST_AXIS_ADAPT;
            end
         end
         mmaf_pkg::ST_SQRT_START: begin
            sq_req.start = 1'b1;
            state_in     = mmaf_pkg::ST_SQRT_WAIT;
         end
         mmaf_pkg::ST_SQRT_WAIT: begin
            if (sq_done) begin
               state_in = mmaf_pkg::ST_MAG_ADAPT;
            end
         end
         mmaf_pkg::ST_MAG_ADAPT: begin
            mdiff_in = mg_d;
            if (mg_d == '0) begin
               mcount_in = '0;
               mgain_in  = mag_gain_base_ff;
            end else begin
               mcount_in  = mg_upd.count;
               mgain_in   = mg_upd.gain;
               mrising_in = mg_rise;
            end
            state_in = mmaf_pkg::ST_MAG_BLEND;
         end
         mmaf_pkg::ST_MAG_BLEND: begin
            if (out_free) begin
               mprev_in     = mg_out;
               rsp_mag_in   = mg_out;
               rsp_valid_in = 1'b1;
               state_in     = mmaf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mmaf_pkg::ST_IDLE;
         end
      endcase
   end

   // Control and filter state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mmaf_pkg::ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         mprev_ff     <= '0;
         mrising_ff   <= 1'b0;
         mcount_ff    <= '0;
         mgain_ff     <= '0;
         for (int i = 0; i < mmaf_pkg::AXES; i++) begin
            prev_ff[i]   <= '0;
            rising_ff[i] <= 1'b0;
            count_ff[i]  <= '0;
            gain_ff[i]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         mprev_ff     <= mprev_in;
         mrising_ff   <= mrising_in;
         mcount_ff    <= mcount_in;
         mgain_ff     <= mgain_in;
         prev_ff      <= prev_in;
         rising_ff    <= rising_in;
         count_ff     <= count_in;
         gain_ff      <= gain_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      accel_ff   <= accel_in;
      diff_ff    <= diff_in;
      ch_ff      <= ch_in;
      sum_ff     <= sum_in;
      mdiff_ff   <= mdiff_in;
      rsp_mag_ff <= rsp_mag_in;
   end

   assign req_stall            = (state_ff != mmaf_pkg::ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_motion_magnitude = rsp_mag_ff;

endmodule

[sv/mmaf_checker.sv]
// Port-level checks of the motion magnitude filter, bound to the top level.
// Depends on motion_magnitude_adaptive_filter_assert.svh for the assertion macros.
`include "motion_magnitude_adaptive_filter_assert.svh"

module mmaf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [13:0] rsp_motion_magnitude
);

   // A stalled result word stays offered and unchanged.
   `MMAF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `MMAF_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_motion_magnitude))

   // Once a word is taken the block is busy with it.
   `MMAF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // A new result shows up exactly when the block frees up for the next word.
   `MMAF_ASSERT_SAME(a_result_frees_input, clock, reset, $rose(rsp_valid), !req_stall)

endmodule

bind motion_magnitude_adaptive_filter mmaf_checker u_mmaf_checker (.*);
